// File: sv/knt_pkg.sv
// Shared types, constants and the reciprocal table of the k-nomial tree neighbor block.
`timescale 1ns / 1ps
`default_nettype none

package knt_pkg;

    localparam int MAX_GROUP   = 4096;
    localparam int MAX_RATIO   = 16;
    localparam int RESULT_CAP  = 45;
    localparam int RANK_W      = 12;
    localparam int SIZE_W      = 13;
    localparam int RATIO_W     = 5;
    localparam int COUNT_W     = 6;
    localparam int DIGIT_W     = 4;
    localparam int POS_W       = $clog2(MAX_RATIO + 1);
    localparam int CHILD_W     = SIZE_W + 1;
    localparam int RECIP_W     = 16;
    localparam int PROD_W      = RANK_W + RECIP_W;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        REG_GROUP_SIZE = 2'd0,
        REG_RADIX      = 2'd1,
        REG_ROOT_RANK  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_COUNT  = 2'd0,
        KIND_LIST   = 2'd1,
        KIND_PARENT = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_PARENT = 2'd1,
        ST_RANGE     = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RANGE,
        OP_COUNT,
        OP_LIST,
        OP_PARENT
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_QUO,
        B_TEST,
        B_CHILD,
        B_PAR,
        B_DONE
    } back_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [RANK_W-1:0]  self_rank;
    } req_t;

    typedef struct packed {
        logic [RANK_W-1:0]  neighbor_rank;
        logic               rank_valid;
        logic [COUNT_W-1:0] child_count;
        status_t            status;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [RATIO_W-1:0] ratio;
        logic [RANK_W-1:0]  root;
        logic               busy;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [RANK_W-1:0]  t;
    } qent_t;

    // ceil(2^16 / k); exact quotient for any 12-bit dividend and k in 2..16.
    function automatic logic [RECIP_W-1:0] recip(input logic [RATIO_W-1:0] k);
        logic [RECIP_W-1:0] r;
        begin
            case (k)
                5'd2:    r = 16'd32768;
                5'd3:    r = 16'd21846;
                5'd4:    r = 16'd16384;
                5'd5:    r = 16'd13108;
                5'd6:    r = 16'd10923;
                5'd7:    r = 16'd9363;
                5'd8:    r = 16'd8192;
                5'd9:    r = 16'd7282;
                5'd10:   r = 16'd6554;
                5'd11:   r = 16'd5958;
                5'd12:   r = 16'd5462;
                5'd13:   r = 16'd5042;
                5'd14:   r = 16'd4682;
                5'd15:   r = 16'd4370;
                5'd16:   r = 16'd4096;
                default: r = 16'd32768;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/knt_cfg.sv
// Configuration registers, their clamped values and the serial reduction of the root rank.
`timescale 1ns / 1ps
`default_nettype none

module knt_cfg
    import knt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [SIZE_W-1:0]  group_size_reg;
    logic [RATIO_W-1:0] radix_reg;
    logic [RANK_W-1:0]  root_rank_reg;
    logic [RANK_W-1:0]  root_eff_reg, root_eff_next;
    logic [RANK_W-1:0]  rem_reg, rem_next;
    logic [DIGIT_W-1:0] bit_reg, bit_next;
    logic               busy_reg, busy_next;
    logic               wr_en;
    reg_idx_t           idx;
    logic [SIZE_W-1:0]  size_eff;
    logic [RATIO_W-1:0] ratio_eff;
    logic [SIZE_W-1:0]  shifted;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        if (group_size_reg == '0)
        begin
            size_eff = SIZE_W'(1);
        end
        else if (group_size_reg > SIZE_W'(MAX_GROUP))
        begin
            size_eff = SIZE_W'(MAX_GROUP);
        end
        else
        begin
            size_eff = group_size_reg;
        end
        if (radix_reg < RATIO_W'(2))
        begin
            ratio_eff = RATIO_W'(2);
        end
        else if (radix_reg > RATIO_W'(MAX_RATIO))
        begin
            ratio_eff = RATIO_W'(MAX_RATIO);
        end
        else
        begin
            ratio_eff = radix_reg;
        end
    end

    always_comb
    begin
        case (idx)
            REG_GROUP_SIZE: prdata = DATA_W'(group_size_reg);
            REG_RADIX:      prdata = DATA_W'(radix_reg);
            REG_ROOT_RANK:  prdata = DATA_W'(root_rank_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= SIZE_W'(1);
            radix_reg      <= RATIO_W'(2);
            root_rank_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_GROUP_SIZE: group_size_reg <= pwdata[SIZE_W-1:0];
                REG_RADIX:      radix_reg      <= pwdata[RATIO_W-1:0];
                REG_ROOT_RANK:  root_rank_reg  <= pwdata[RANK_W-1:0];
                default:        ;
            endcase
        end
    end

    // Restoring remainder of the root rank by the group size, one bit a cycle.
    always_comb
    begin
        shifted       = {rem_reg, root_rank_reg[bit_reg]};
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        busy_next     = busy_reg;
        root_eff_next = root_eff_reg;
        if (wr_en && (idx == REG_GROUP_SIZE || idx == REG_ROOT_RANK))
        begin
            busy_next = 1'b1;
            bit_next  = DIGIT_W'(RANK_W - 1);
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= size_eff)
            begin
                rem_next = RANK_W'(shifted - size_eff);
            end
            else
            begin
                rem_next = shifted[RANK_W-1:0];
            end
            if (bit_reg == '0)
            begin
                busy_next     = 1'b0;
                root_eff_next = rem_next;
            end
            else
            begin
                bit_next = bit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            bit_reg      <= '0;
            rem_reg      <= '0;
            root_eff_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            bit_reg      <= bit_next;
            rem_reg      <= rem_next;
            root_eff_reg <= root_eff_next;
        end
    end

    assign cfg.size  = size_eff;
    assign cfg.ratio = ratio_eff;
    assign cfg.root  = root_eff_reg;
    assign cfg.busy  = busy_reg;

endmodule

`default_nettype wire

// File: sv/knt_front.sv
// Front end: accepts request items, checks them and turns the self rank into a tree rank.
`timescale 1ns / 1ps
`default_nettype none

module knt_front
    import knt_pkg::*;
(
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    input  wire cfg_t cfg,
    input  wire logic q_full,
    output logic      q_push,
    output qent_t     q_data
);

    logic [CHILD_W-1:0] sum;

    assign req_stall = cfg.busy || q_full;
    assign q_push    = req_valid && !req_stall;

    always_comb
    begin
        sum = CHILD_W'(req.self_rank) + CHILD_W'(cfg.size) - CHILD_W'(cfg.root);
        if (sum >= CHILD_W'(cfg.size))
        begin
            sum = sum - CHILD_W'(cfg.size);
        end
        q_data.t = sum[RANK_W-1:0];
        if (req.kind == KIND_UNUSED)
        begin
            q_data.op = OP_NONE;
        end
        else if (SIZE_W'(req.self_rank) >= cfg.size)
        begin
            q_data.op = OP_RANGE;
        end
        else
        begin
            case (req.kind)
                KIND_COUNT:  q_data.op = OP_COUNT;
                KIND_LIST:   q_data.op = OP_LIST;
                KIND_PARENT: q_data.op = OP_PARENT;
                default:     q_data.op = OP_NONE;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/knt_queue.sv
// Short register queue of checked requests between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module knt_queue
    import knt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire qent_t push_data,
    input  wire logic  pop,
    output logic       full,
    output logic       empty,
    output qent_t      head
);

    qent_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]    count_reg, count_next;
    logic                do_pop;

    assign full   = (count_reg == (Q_PTR_W + 1)'(Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/knt_back.sv
// Back end: digit scan of the tree rank, child walk, parent search and the result register.
`timescale 1ns / 1ps
`default_nettype none

module knt_back
    import knt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic q_empty,
    input  wire qent_t q_head,
    output logic      q_pop,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    back_state_t         state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [RANK_W-1:0]   t_reg, t_next;
    logic [RANK_W-1:0]   rest_reg, rest_next;
    logic [SIZE_W-1:0]   inc_reg, inc_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [RANK_W-1:0]   q_reg, q_next;
    logic [RANK_W-1:0]   qk_reg, qk_next;
    logic [CHILD_W-1:0]  child_reg, child_next;
    logic [DIGIT_W-1:0]  i_reg, i_next;
    logic [DIGIT_W-1:0]  digit_reg, digit_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [RANK_W-1:0]   pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    logic                slot_free;
    logic                emit;
    rsp_t                emit_item;
    logic [RANK_W+RATIO_W-1:0]  qk_full;
    logic [SIZE_W+RATIO_W-1:0]  inc_full;
    logic [SIZE_W+DIGIT_W-1:0]  par_full;
    logic [RANK_W-1:0]   digit_diff;
    logic [RATIO_W-1:0]  ratio_m1;

    function automatic logic [RANK_W-1:0] rotate_out(
        input logic [RANK_W-1:0] x,
        input logic [RANK_W-1:0] root,
        input logic [SIZE_W-1:0] size
    );
        logic [SIZE_W-1:0] s;
        begin
            s = SIZE_W'(x) + SIZE_W'(root);
            if (s >= size)
            begin
                s = s - size;
            end
            return s[RANK_W-1:0];
        end
    endfunction

    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign qk_full    = (RANK_W + RATIO_W)'(prod_reg[PROD_W-1:RECIP_W])
                        * (RANK_W + RATIO_W)'(cfg.ratio);
    assign inc_full   = (SIZE_W + RATIO_W)'(inc_reg) * (SIZE_W + RATIO_W)'(cfg.ratio);
    assign par_full   = (SIZE_W + DIGIT_W)'(digit_reg) * (SIZE_W + DIGIT_W)'(inc_reg);
    assign digit_diff = rest_reg - qk_reg;
    assign ratio_m1   = cfg.ratio - 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        t_next          = t_reg;
        rest_next       = rest_reg;
        inc_next        = inc_reg;
        prod_next       = prod_reg;
        q_next          = q_reg;
        qk_next         = qk_reg;
        child_next      = child_reg;
        i_next          = i_reg;
        digit_next      = digit_reg;
        pos_next        = pos_reg;
        n_next          = n_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        q_pop           = 1'b0;
        emit            = 1'b0;
        emit_item       = '0;
        emit_item.status = ST_OK;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop           = 1'b1;
                    op_next         = q_head.op;
                    t_next          = q_head.t;
                    rest_next       = q_head.t;
                    inc_next        = SIZE_W'(1);
                    pos_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    case (q_head.op)
                        OP_COUNT, OP_LIST: state_next = B_MUL;
                        OP_PARENT:
                        begin
                            state_next = (q_head.t == '0) ? B_DONE : B_MUL;
                        end
                        default:           state_next = B_DONE;
                    endcase
                end
            end
            B_MUL:
            begin
                prod_next  = PROD_W'(rest_reg) * PROD_W'(recip(cfg.ratio));
                state_next = B_QUO;
            end
            B_QUO:
            begin
                q_next     = prod_reg[PROD_W-1:RECIP_W];
                qk_next    = qk_full[RANK_W-1:0];
                state_next = B_TEST;
            end
            B_TEST:
            begin
                if (op_reg == OP_PARENT)
                begin
                    if (qk_reg == rest_reg)
                    begin
                        rest_next  = q_reg;
                        inc_next   = inc_full[SIZE_W-1:0];
                        state_next = B_MUL;
                    end
                    else
                    begin
                        digit_next = digit_diff[DIGIT_W-1:0];
                        state_next = B_PAR;
                    end
                end
                else if (qk_reg == rest_reg && pos_reg != POS_W'(MAX_RATIO))
                begin
                    child_next = CHILD_W'(t_reg) + CHILD_W'(inc_reg);
                    i_next     = DIGIT_W'(1);
                    state_next = B_CHILD;
                end
                else
                begin
                    state_next = B_DONE;
                end
            end
            B_CHILD:
            begin
                if (child_reg >= CHILD_W'(cfg.size) || n_reg == COUNT_W'(RESULT_CAP))
                begin
                    state_next = B_DONE;
                end
                else if (op_reg == OP_LIST && pend_valid_reg && !slot_free)
                begin
                    state_next = B_CHILD;
                end
                else
                begin
                    if (op_reg == OP_LIST && pend_valid_reg)
                    begin
                        emit                    = 1'b1;
                        emit_item.neighbor_rank = rotate_out(pend_reg, cfg.root, cfg.size);
                        emit_item.rank_valid    = 1'b1;
                    end
                    pend_next       = child_reg[RANK_W-1:0];
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + 1'b1;
                    if (RATIO_W'(i_reg) == ratio_m1)
                    begin
                        rest_next  = q_reg;
                        inc_next   = inc_full[SIZE_W-1:0];
                        pos_next   = pos_reg + 1'b1;
                        state_next = B_MUL;
                    end
                    else
                    begin
                        child_next = child_reg + CHILD_W'(inc_reg);
                        i_next     = i_reg + 1'b1;
                    end
                end
            end
            B_PAR:
            begin
                pend_next       = t_reg - par_full[RANK_W-1:0];
                pend_valid_next = 1'b1;
                state_next      = B_DONE;
            end
            B_DONE:
            begin
                if (slot_free)
                begin
                    emit           = 1'b1;
                    emit_item.last = 1'b1;
                    case (op_reg)
                        OP_RANGE: emit_item.status = ST_RANGE;
                        OP_COUNT: emit_item.child_count = n_reg;
                        OP_LIST, OP_PARENT:
                        begin
                            if (pend_valid_reg)
                            begin
                                emit_item.neighbor_rank =
                                    rotate_out(pend_reg, cfg.root, cfg.size);
                                emit_item.rank_valid    = 1'b1;
                            end
                            else if (op_reg == OP_PARENT)
                            begin
                                emit_item.status = ST_NO_PARENT;
                            end
                        end
                        default:  emit_item.status = ST_OK;
                    endcase
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        t_reg     <= t_next;
        rest_reg  <= rest_next;
        inc_reg   <= inc_next;
        prod_reg  <= prod_next;
        q_reg     <= q_next;
        qk_reg    <= qk_next;
        child_reg <= child_next;
        i_reg     <= i_next;
        digit_reg <= digit_next;
        pos_reg   <= pos_next;
        n_reg     <= n_next;
        pend_reg  <= pend_next;
        if (emit)
        begin
            rsp_reg <= emit_item;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: sv/knomial_tree_neighbors.sv
// Top level of the k-nomial broadcast tree neighbor block.
//
//   Channel  Direction  Handshake                Payload
//   req      in         req_valid / req_stall    req_t   {kind, self_rank}
//   rsp      out        rsp_valid / rsp_stall    rsp_t   {neighbor_rank, rank_valid,
//                                                         child_count, status, last}
//   cfg      in         APB psel/penable/pready  group_size, radix, root_rank
//
// The front end checks and queues a request; the back end serves one at a time. Count
// and list scan the digit positions of the tree rank and step once per child; a parent
// request scans the trailing zero digits. A write to group_size or root_rank stalls
// requests while the root is reduced. Reset is asynchronous; a stalled result holds in
// its output register.
`timescale 1ns / 1ps
`default_nettype none

module knomial_tree_neighbors
    import knt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire req_t              req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output rsp_t                   rsp
);

    cfg_t  cfg;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;
    qent_t q_data;
    qent_t q_head;

    knt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    knt_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cfg       (cfg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    knt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    knt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: tb/knomial_tree_neighbors_test.sv
// Self-checking testbench for the k-nomial tree neighbor block: directed and random requests.
`timescale 1ns / 1ps

module knomial_tree_neighbors_test;
    import knt_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 40;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_t              req_item = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rsp_t              rsp_item;

    logic [SIZE_W-1:0]  cfg_group_size = SIZE_W'(1);
    logic [RATIO_W-1:0] cfg_radix = RATIO_W'(2);
    logic [RANK_W-1:0]  cfg_root_rank = '0;

    rsp_t expected_rsps [$];
    int   mismatch_count = 0;
    int   cycle_count = 0;
    int   gap_pct = 0;
    int   stall_pct = 0;
    int   stall_left = 0;

    knomial_tree_neighbors u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_item)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        if ($urandom_range(7) == 0)
            return $urandom_range(30, 8);
        return $urandom_range(3, 1);
    endfunction

    // Registers as the block uses them: clamped size and ratio, root reduced by size.
    function automatic void resolve_tree(output int unsigned size, output int unsigned k,
                                         output int unsigned root);
        size = cfg_group_size;
        if (size == 0)
            size = 1;
        if (size > MAX_GROUP)
            size = MAX_GROUP;
        k = cfg_radix;
        if (k < 2)
            k = 2;
        if (k > MAX_RATIO)
            k = MAX_RATIO;
        root = cfg_root_rank % size;
    endfunction

    function automatic void predict_neighbors(req_t r);
        int unsigned size, k, root, t, rest, inc, child, g, p, parent;
        int pos, i;
        bit stop;
        int unsigned kids [$];
        rsp_t res;
        resolve_tree(size, k, root);
        res = '0;
        res.last = 1'b1;
        if (r.kind == KIND_UNUSED)
        begin
            expected_rsps.push_back(res);
            return;
        end
        if (r.self_rank >= size)
        begin
            res.status = ST_RANGE;
            expected_rsps.push_back(res);
            return;
        end
        t = (r.self_rank + size - root) % size;
        if (r.kind == KIND_PARENT)
        begin
            if (t == 0)
                res.status = ST_NO_PARENT;
            else
            begin
                rest = t;
                p = 1;
                while (rest % k == 0)
                begin
                    rest = rest / k;
                    p = p * k;
                end
                parent = t - (rest % k) * p;
                g = parent + root;
                if (g >= size)
                    g = g - size;
                res.neighbor_rank = RANK_W'(g);
                res.rank_valid = 1'b1;
            end
            expected_rsps.push_back(res);
            return;
        end
        // Children lie at t + i*k^pos while the digits of t below pos are zero.
        rest = t;
        inc = 1;
        stop = 1'b0;
        for (pos = 0; pos < MAX_RATIO && !stop && rest % k == 0; pos++)
        begin
            for (i = 1; i < k && !stop; i++)
            begin
                child = t + i * inc;
                if (child >= size || kids.size() >= RESULT_CAP)
                    stop = 1'b1;
                else
                begin
                    g = child + root;
                    if (g >= size)
                        g = g - size;
                    kids.push_back(g);
                end
            end
            rest = rest / k;
            inc = inc * k;
        end
        if (r.kind == KIND_COUNT)
        begin
            res.child_count = COUNT_W'(kids.size());
            expected_rsps.push_back(res);
        end
        else if (kids.size() == 0)
            expected_rsps.push_back(res);
        else
        begin
            foreach (kids[j])
            begin
                res.neighbor_rank = RANK_W'(kids[j]);
                res.rank_valid = 1'b1;
                res.last = (j == kids.size() - 1);
                expected_rsps.push_back(res);
            end
        end
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected item, expected none, actual %p", $time, rsp_item);
            end
            else
            begin
                want = expected_rsps.pop_front();
                check_field("neighbor_rank", want.neighbor_rank, rsp_item.neighbor_rank);
                check_field("rank_valid", want.rank_valid, rsp_item.rank_valid);
                check_field("child_count", want.child_count, rsp_item.child_count);
                check_field("status", want.status, rsp_item.status);
                check_field("last", want.last, rsp_item.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(99) < stall_pct)
        begin
            rsp_stall <= 1'b1;
            stall_left <= pick_gap() - 1;
        end
        else
            rsp_stall <= 1'b0;
    end

    task automatic send_request(kind_t kind, logic [RANK_W-1:0] self_rank);
        req_t r;
        int unsigned gap;
        r.kind = kind;
        r.self_rank = self_rank;
        gap = ($urandom_range(99) < gap_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item <= r;
        do
            @(posedge clk);
        while (req_stall);
        predict_neighbors(r);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_GROUP_SIZE: cfg_group_size = value[SIZE_W-1:0];
            REG_RADIX:      cfg_radix = value[RATIO_W-1:0];
            default:        cfg_root_rank = value[RANK_W-1:0];
        endcase
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(int unsigned size, int unsigned ratio, int unsigned root);
        wait_idle();
        write_reg(REG_GROUP_SIZE, size);
        write_reg(REG_RADIX, ratio);
        write_reg(REG_ROOT_RANK, root);
    endtask

    // A single-rank group straight out of reset: the only rank is the root.
    task automatic test_reset_values();
        gap_pct = 0;
        stall_pct = 0;
        send_request(KIND_COUNT, '0);
        send_request(KIND_LIST, '0);
        send_request(KIND_PARENT, '0);
        send_request(KIND_PARENT, '1);
        send_request(KIND_UNUSED, '1);
    endtask

    // Largest tree with the widest radix, where the root list hits the result cap.
    task automatic test_full_tree();
        gap_pct = 30;
        stall_pct = 30;
        set_config(MAX_GROUP, MAX_RATIO, 0);
        send_request(KIND_LIST, '0);
        send_request(KIND_COUNT, '0);
        send_request(KIND_PARENT, '1);
        send_request(KIND_COUNT, '1);
        send_request(KIND_LIST, '1);
        send_request(KIND_UNUSED, '0);
    endtask

    // Register values outside their useful ranges are clamped or reduced.
    task automatic test_clamping();
        gap_pct = 20;
        stall_pct = 20;
        set_config(8191, 31, 4095);
        send_request(KIND_LIST, 12'd4095);
        send_request(KIND_PARENT, 12'd0);
        send_request(KIND_COUNT, 12'd2048);
        set_config(0, 0, 4095);
        send_request(KIND_COUNT, 12'd0);
        send_request(KIND_PARENT, 12'd0);
        send_request(KIND_LIST, 12'd1);
        set_config(4097, 1, 7);
        send_request(KIND_LIST, 12'd7);
        send_request(KIND_PARENT, 12'd6);
    endtask

    task automatic test_random_traffic();
        int unsigned size, k, root, t, step, size_reg, ratio_reg;
        int unsigned pick;
        int j;
        kind_t kind;
        logic [RANK_W-1:0] self_rank;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    size_reg = 4096;
                    ratio_reg = 2;
                end
                1:
                begin
                    size_reg = $urandom_range(64, 1);
                    ratio_reg = $urandom_range(16, 2);
                end
                2:
                begin
                    size_reg = $urandom_range(4096, 1);
                    ratio_reg = $urandom_range(31);
                end
                3:
                begin
                    size_reg = $urandom_range(8191);
                    ratio_reg = 16;
                end
                4:
                begin
                    size_reg = 4096;
                    ratio_reg = 16;
                end
                default:
                begin
                    size_reg = $urandom_range(300, 2);
                    ratio_reg = $urandom_range(7, 3);
                end
            endcase
            set_config(size_reg, ratio_reg, $urandom_range(4095));
            gap_pct = (phase % 3 == 0) ? 0 : 30;
            stall_pct = (phase % 3 == 0) ? 0 : 30;
            resolve_tree(size, k, root);
            for (int n = 0; n < 15; n++)
            begin
                pick = $urandom_range(99);
                kind = kind_t'($urandom_range(2));
                if (pick < 10)
                begin
                    kind = KIND_UNUSED;
                    self_rank = $urandom_range(4095);
                end
                else if (pick < 20)
                begin
                    kind = kind_t'($urandom_range(3));
                    self_rank = $urandom_range(4095);
                end
                else
                begin
                    // Ranks with trailing zero digits have children deeper in the tree.
                    t = $urandom_range(size - 1);
                    if (pick < 50)
                    begin
                        step = 1;
                        for (j = $urandom_range(3); j > 0; j--)
                            step = step * k;
                        t = (t / step) * step;
                    end
                    self_rank = RANK_W'((t + root) % size);
                end
                send_request(kind, self_rank);
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_full_tree();
        test_clamping();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_rsps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
